>>> sv/lkt_pkg.sv
// Package: shared types, action codes and control structs for the LRU keyed table.
package lkt_pkg;

    // Fixed field widths of the item ports.
    localparam int KEY_W   = 64;
    localparam int DATA_W  = 32;

    typedef logic [KEY_W-1:0]  t_key;
    typedef logic [DATA_W-1:0] t_data;

    // Action codes of an input item.
    typedef enum logic [1:0] {
        ACT_INSERT = 2'd0,
        ACT_LOOKUP = 2'd1,
        ACT_REMOVE = 2'd2,
        ACT_NONE   = 2'd3
    } t_action;

    // Controller states.
    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_SCAN_DRAIN,
        ST_DECIDE,
        ST_UPDATE,
        ST_UPD_DRAIN
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic clear_wr;  // write one metadata entry to invalid and step
        logic load;      // capture the accepted item and restart the sweep
        logic scan_rd;   // read one entry for the key search and step
        logic decide;    // apply the search outcome and restart the sweep
        logic upd_rd;    // read one entry for the recency update and step
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic idx_last;     // sweep counter is at the last slot
        logic need_update;  // the current item changes recency or validity
        logic is_lookup;    // the current item produces a result
        logic out_busy;     // the result register holds an item not yet taken
    } t_stat;

endpackage

>>> sv/lkt_ctrl.sv
// Controller: state machine that sequences the search and update sweeps.
module lkt_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  lkt_pkg::t_stat i_stat,
    output lkt_pkg::t_cmd  o_cmd
);

    lkt_pkg::t_state r_state;
    lkt_pkg::t_state n_state;

    // State register; reset starts the metadata clearing pass.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= lkt_pkg::ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and commands.
    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            lkt_pkg::ST_CLEAR: begin
                o_cmd.clear_wr = 1'b1;
                if (i_stat.idx_last) begin
                    n_state = lkt_pkg::ST_IDLE;
                end
            end
            lkt_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = lkt_pkg::ST_SCAN;
                end
            end
            lkt_pkg::ST_SCAN: begin
                o_cmd.scan_rd = 1'b1;
                if (i_stat.idx_last) begin
                    n_state = lkt_pkg::ST_SCAN_DRAIN;
                end
            end
            lkt_pkg::ST_SCAN_DRAIN: begin
                n_state = lkt_pkg::ST_DECIDE;
            end
            lkt_pkg::ST_DECIDE: begin
                // A lookup waits here until the result register is free.
                if (!(i_stat.is_lookup && i_stat.out_busy)) begin
                    o_cmd.decide = 1'b1;
                    n_state = i_stat.need_update ? lkt_pkg::ST_UPDATE : lkt_pkg::ST_IDLE;
                end
            end
            lkt_pkg::ST_UPDATE: begin
                o_cmd.upd_rd = 1'b1;
                if (i_stat.idx_last) begin
                    n_state = lkt_pkg::ST_UPD_DRAIN;
                end
            end
            lkt_pkg::ST_UPD_DRAIN: begin
                n_state = lkt_pkg::ST_IDLE;
            end
            default: begin
                n_state = lkt_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

>>> sv/lkt_datapath.sv
// Datapath: entry memories, sweep counter, key search, recency update and result register.
module lkt_datapath #(
    parameter int CAPACITY    = 64,
    parameter int VALUE_WIDTH = 32
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  lkt_pkg::t_cmd    i_cmd,
    output lkt_pkg::t_stat   o_stat,
    input  logic [1:0]       i_action,
    input  lkt_pkg::t_key    i_key,
    input  lkt_pkg::t_data   i_value,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output logic             o_found,
    output lkt_pkg::t_data   o_found_value
);

    localparam int AW = $clog2(CAPACITY);
    localparam int MW = AW + 1;
    localparam int VW = (VALUE_WIDTH < lkt_pkg::DATA_W) ? VALUE_WIDTH : lkt_pkg::DATA_W;
    localparam logic [AW-1:0] LAST_IDX = AW'(CAPACITY - 1);
    localparam logic [AW:0]   FULL_CNT = MW'(CAPACITY);

    // Metadata word: valid bit on top, recency rank below (0 is most recent).
    logic [MW-1:0]         meta_mem [CAPACITY];
    lkt_pkg::t_key         key_mem  [CAPACITY];
    logic [VW-1:0]         val_mem  [CAPACITY];

    // Sweep counter and read pipeline.
    logic [AW-1:0]         r_idx;
    logic [AW-1:0]         r_q_idx;
    logic                  r_q_scan;
    logic                  r_q_upd;
    logic [MW-1:0]         r_meta_q;
    lkt_pkg::t_key         r_key_q;
    logic [VW-1:0]         r_val_q;

    // Current item.
    logic [1:0]            r_action;
    lkt_pkg::t_key         r_key;
    logic [VW-1:0]         r_value;

    // Search outcome.
    logic                  r_hit;
    logic                  r_free_found;
    logic [AW-1:0]         r_hit_slot;
    logic [AW-1:0]         r_hit_rank;
    logic [VW-1:0]         r_hit_val;
    logic [AW-1:0]         r_free_slot;
    logic [AW-1:0]         r_lru_slot;

    // Update plan and occupancy.
    logic [AW-1:0]         r_target;
    logic [AW-1:0]         r_rank;
    logic                  r_drop;
    logic [AW:0]           r_count;

    // Result register.
    logic                  r_out_valid;
    logic                  r_found;
    lkt_pkg::t_data        r_found_value;

    // Decision signals.
    logic                  full;
    logic                  need_upd;
    logic                  wr_key;
    logic                  wr_val;
    logic                  cnt_inc;
    logic                  cnt_dec;
    logic                  out_load;
    logic                  drop;
    logic [AW-1:0]         tgt;
    logic [AW-1:0]         rank;

    // Update sweep signals.
    logic                  q_v;
    logic [AW-1:0]         q_age;
    logic [MW-1:0]         new_meta;
    logic                  idx_last;
    logic                  step;

    assign idx_last = (r_idx == LAST_IDX);
    assign step     = i_cmd.clear_wr | i_cmd.scan_rd | i_cmd.upd_rd;
    assign full     = (r_count == FULL_CNT);
    assign q_v      = r_meta_q[AW];
    assign q_age    = r_meta_q[AW-1:0];

    // Sweep counter and pipeline control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx    <= '0;
            r_q_scan <= 1'b0;
            r_q_upd  <= 1'b0;
        end else begin
            if (i_cmd.load || i_cmd.decide) begin
                r_idx <= '0;
            end else if (step) begin
                r_idx <= idx_last ? '0 : r_idx + AW'(1);
            end
            r_q_scan <= i_cmd.scan_rd;
            r_q_upd  <= i_cmd.upd_rd;
        end
    end

    always_ff @(posedge i_clk) begin
        r_q_idx <= r_idx;
    end

    // Metadata memory: cleared after reset, rewritten by the update sweep.
    always_ff @(posedge i_clk) begin
        if (i_cmd.clear_wr) begin
            meta_mem[r_idx] <= '0;
        end else if (r_q_upd) begin
            meta_mem[r_q_idx] <= new_meta;
        end
        r_meta_q <= meta_mem[r_idx];
    end

    // Key memory.
    always_ff @(posedge i_clk) begin
        if (i_cmd.decide && wr_key) begin
            key_mem[tgt] <= r_key;
        end
        r_key_q <= key_mem[r_idx];
    end

    // Value memory.
    always_ff @(posedge i_clk) begin
        if (i_cmd.decide && wr_val) begin
            val_mem[tgt] <= r_value;
        end
        r_val_q <= val_mem[r_idx];
    end

    // Item capture.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_action <= i_action;
            r_key    <= i_key;
            r_value  <= i_value[VW-1:0];
        end
    end

    // Search flags.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hit        <= 1'b0;
            r_free_found <= 1'b0;
        end else if (i_cmd.load) begin
            r_hit        <= 1'b0;
            r_free_found <= 1'b0;
        end else if (r_q_scan) begin
            if (q_v && (r_key_q == r_key)) begin
                r_hit <= 1'b1;
            end
            if (!q_v) begin
                r_free_found <= 1'b1;
            end
        end
    end

    // Search payload: matching slot, lowest free slot and least recent slot.
    always_ff @(posedge i_clk) begin
        if (r_q_scan) begin
            if (q_v && (r_key_q == r_key) && !r_hit) begin
                r_hit_slot <= r_q_idx;
                r_hit_rank <= q_age;
                r_hit_val  <= r_val_q;
            end
            if (!q_v && !r_free_found) begin
                r_free_slot <= r_q_idx;
            end
            if (q_v && (q_age == LAST_IDX)) begin
                r_lru_slot <= r_q_idx;
            end
        end
    end

    // Decision from the search outcome.
    always_comb begin
        need_upd = 1'b0;
        wr_key   = 1'b0;
        wr_val   = 1'b0;
        cnt_inc  = 1'b0;
        cnt_dec  = 1'b0;
        out_load = 1'b0;
        drop     = 1'b0;
        tgt      = r_hit_slot;
        rank     = r_hit_rank;
        case (r_action)
            lkt_pkg::ACT_INSERT: begin
                need_upd = 1'b1;
                wr_val   = 1'b1;
                if (!r_hit) begin
                    wr_key = 1'b1;
                    if (!full) begin
                        tgt     = r_free_slot;
                        rank    = r_count[AW-1:0];
                        cnt_inc = 1'b1;
                    end else begin
                        tgt  = r_lru_slot;
                        rank = LAST_IDX;
                    end
                end
            end
            lkt_pkg::ACT_LOOKUP: begin
                out_load = 1'b1;
                need_upd = r_hit;
            end
            lkt_pkg::ACT_REMOVE: begin
                need_upd = r_hit;
                drop     = 1'b1;
                cnt_dec  = r_hit;
            end
            default: begin
                need_upd = 1'b0;
            end
        endcase
    end

    // Occupancy count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.decide) begin
            if (cnt_inc) begin
                r_count <= r_count + MW'(1);
            end else if (cnt_dec) begin
                r_count <= r_count - MW'(1);
            end
        end
    end

    // Update plan for the sweep.
    always_ff @(posedge i_clk) begin
        if (i_cmd.decide) begin
            r_target <= tgt;
            r_rank   <= rank;
            r_drop   <= drop;
        end
    end

    // New metadata of one slot during the update sweep.
    always_comb begin
        new_meta = r_meta_q;
        if (r_q_idx == r_target) begin
            new_meta = r_drop ? '0 : {1'b1, AW'(0)};
        end else if (q_v) begin
            if (!r_drop && (q_age < r_rank)) begin
                new_meta = {1'b1, q_age + AW'(1)};
            end else if (r_drop && (q_age > r_rank)) begin
                new_meta = {1'b1, q_age - AW'(1)};
            end
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.decide && out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.decide && out_load) begin
            r_found       <= r_hit;
            r_found_value <= r_hit ? lkt_pkg::t_data'(r_hit_val) : '0;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_found       = r_found;
    assign o_found_value = r_found_value;

    // Status to the controller.
    always_comb begin
        o_stat.idx_last    = idx_last;
        o_stat.need_update = need_upd;
        o_stat.is_lookup   = (r_action == lkt_pkg::ACT_LOOKUP);
        o_stat.out_busy    = r_out_valid && !i_out_ready;
    end

endmodule

>>> sv/lru_keyed_table.sv
// Top level: fully associative keyed table with least-recently-used replacement.
//
//   Channel  Handshake                  Payload
//   input    i_in_valid / o_in_ready    i_action, i_key, i_value
//   output   o_out_valid / i_out_ready  o_found, o_found_value (lookup only)
//
// An item that changes the table takes one sweep over the entry memories for the key
// search and one read-modify-write sweep over the metadata memory for the recency
// update, one slot per cycle; a lookup miss, a remove miss or an unused action takes
// the search sweep only. After reset a clearing pass marks every slot invalid; no
// item is accepted during it. A lookup result waits in an output register, and the
// next item is accepted while it waits; a lookup only stalls if that register is
// still full.
module lru_keyed_table #(
    parameter int CAPACITY    = 64,
    parameter int VALUE_WIDTH = 32
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  logic [1:0]     i_action,
    input  lkt_pkg::t_key  i_key,
    input  lkt_pkg::t_data i_value,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output logic           o_found,
    output lkt_pkg::t_data o_found_value
);

    lkt_pkg::t_cmd  cmd;
    lkt_pkg::t_stat stat;

    // Sequencing of the sweeps.
    lkt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    // Memories, search, update and result register.
    lkt_datapath #(
        .CAPACITY    (CAPACITY),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_stat        (stat),
        .i_action      (i_action),
        .i_key         (i_key),
        .i_value       (i_value),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_found       (o_found),
        .o_found_value (o_found_value)
    );

endmodule
